// ----- rtl/core/mad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mad_pkg
// Shared types, field masks and lookup tables of the MPEG audio header decoder.
// ----------------------------------------------------------------------------
package mad_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] SyncMask    = 32'hffe00000;
  localparam logic [31:0] LayerMask   = 32'h00060000;
  localparam logic [31:0] BitrateMask = 32'h0000f000;
  localparam logic [31:0] RateMask    = 32'h00000c00;

  localparam logic [1:0] LayerBitsL3 = 2'd1;
  localparam logic [1:0] ModeMono    = 2'd3;

  localparam int unsigned NumFreq = 9;

  typedef logic [8:0]  kbps_t;
  typedef logic [10:0] fbytes_t;
  typedef kbps_t   kbps_row_t [16];
  typedef fbytes_t fbytes_row_t [16];

  // Layer III bitrates, MPEG-1 row then low sampling frequency row
  localparam kbps_row_t KbpsL3 [2] = '{
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // Frame bytes without padding: kbps * 144000 / (freq << lsf), by freq and bitrate index
  localparam fbytes_row_t FrameBytes [NumFreq] = '{
    '{11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
      11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0},
    '{11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
      11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0},
    '{11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
      11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0},
    '{11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
      11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0},
    '{11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
      11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0},
    '{11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
      11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0},
    '{11'd0, 11'd52, 11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
      11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044, 11'd0},
    '{11'd0, 11'd48, 11'd96, 11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
      11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864, 11'd960, 11'd0},
    '{11'd0, 11'd72, 11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
      11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440, 11'd0}
  };

  // Classified header word, passed from the front end to the back end
  typedef struct packed {
    logic       ok;
    logic [1:0] layer_number;
    logic       lsf;
    logic       v25;
    logic [3:0] freq_index;
    logic       crc;
    kbps_t      kbps;
    logic       pad;
    logic [1:0] mode;
    logic [1:0] stereo_ext;
    fbytes_t    fbytes;
  } class_t;

endpackage
`default_nettype wire

// ----- rtl/core/mad_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mad_front
// Splits a candidate header word into its fields, checks it and looks up the
// bitrate and the unpadded frame size.
// ----------------------------------------------------------------------------
module mad_front (
  input  wire logic [31:0]     word_i,
  output mad_pkg::class_t      class_o
);

  logic [1:0] layer_bits;
  logic [3:0] rate_idx;
  logic [1:0] sf;
  logic       v25;
  logic       lsf;
  logic       ok;
  logic [3:0] fidx;

  always_comb begin
    layer_bits = word_i[18:17];
    rate_idx   = word_i[15:12];
    sf         = word_i[11:10];
    v25        = ~word_i[20];
    lsf        = v25 | ~word_i[19];

    ok = ((word_i & mad_pkg::SyncMask) == mad_pkg::SyncMask)
      && ((word_i & mad_pkg::LayerMask) != 32'd0)
      && ((word_i & mad_pkg::BitrateMask) != 32'd0)
      && ((word_i & mad_pkg::BitrateMask) != mad_pkg::BitrateMask)
      && ((word_i & mad_pkg::RateMask) != mad_pkg::RateMask)
      && (layer_bits == mad_pkg::LayerBitsL3);

    // sf is at most 2 on a good header, so the index stays within the table
    if (!ok) begin
      fidx = 4'd0;
    end else if (v25) begin
      fidx = 4'd6 + {2'b00, sf};
    end else begin
      fidx = {2'b00, sf} + (lsf ? 4'd3 : 4'd0);
    end

    class_o.ok           = ok;
    class_o.layer_number = 2'd0 - layer_bits;
    class_o.lsf          = lsf;
    class_o.v25          = v25;
    class_o.freq_index   = fidx;
    class_o.crc          = ~word_i[16];
    class_o.pad          = word_i[9];
    class_o.mode         = word_i[7:6];
    class_o.stereo_ext   = word_i[5:4];
    class_o.kbps         = ok ? mad_pkg::KbpsL3[lsf][rate_idx] : 9'd0;
    class_o.fbytes       = ok ? mad_pkg::FrameBytes[fidx][rate_idx] : 11'd0;
  end

endmodule
`default_nettype wire

// ----- rtl/core/mad_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mad_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module mad_queue #(
  parameter int unsigned Depth = mad_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mad_pkg::class_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output mad_pkg::class_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mad_pkg::class_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mad_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mad_back
// Works out header/side-info length and frame data length of a classified
// word and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module mad_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            avail_i,
  input  wire mad_pkg::class_t class_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output mad_pkg::class_t      res_o,
  output logic [8:0]           side_bits_o,
  output logic [13:0]          data_bits_o
);

  localparam logic [14:0] DataMax = 15'd16383;

  logic            valid_q;
  mad_pkg::class_t res_q;
  logic [8:0]      side_bits_q, side_bits_d;
  logic [13:0]     data_bits_q, data_bits_d;
  logic            load;
  logic [5:0]      hbytes;
  logic [11:0]     fbytes;
  logic [14:0]     fbits;
  logic [14:0]     hbits_w;
  logic [14:0]     diff;

  // refill the output register when it is empty or being taken
  assign load   = ~valid_q | ~out_stall_i;
  assign take_o = load & avail_i;

  always_comb begin
    if (class_i.lsf) begin
      hbytes = (class_i.mode == mad_pkg::ModeMono) ? 6'd9 : 6'd17;
    end else begin
      hbytes = (class_i.mode == mad_pkg::ModeMono) ? 6'd17 : 6'd32;
    end
    hbytes  = hbytes + (class_i.crc ? 6'd2 : 6'd0) + 6'd4;
    fbytes  = {1'b0, class_i.fbytes} + {11'd0, class_i.pad};
    fbits   = {fbytes, 3'b000};
    hbits_w = {6'd0, hbytes, 3'b000};
    diff    = fbits - hbits_w;

    if (!class_i.ok) begin
      side_bits_d = 9'd0;
      data_bits_d = 14'd0;
    end else begin
      side_bits_d = {hbytes, 3'b000};
      if (fbits <= hbits_w) begin
        data_bits_d = 14'd0;
      end else if (diff > DataMax) begin
        data_bits_d = DataMax[13:0];
      end else begin
        data_bits_d = diff[13:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q       <= class_i;
      side_bits_q <= side_bits_d;
      data_bits_q <= data_bits_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
  assign side_bits_o = side_bits_q;
  assign data_bits_o = data_bits_q;

endmodule
`default_nettype wire

// ----- rtl/core/mpeg_audio_header_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder
// Layer III MPEG audio frame header check and decode, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Takes one candidate 32-bit header word per clock while not stalled and
// returns one result per word, in order. A word is taken whenever the input
// queue has room, so with no stall at the output the block sustains one word
// every cycle; an accepted word passes through the queue and then the output
// register, where its result is held until taken. The front end checks the
// word and looks up bitrate and frame size from constant tables; the back end
// adds padding and subtracts header/side-info length. A stall at the output
// is absorbed by the QDepth-entry queue before in_stall_o rises. When
// header_ok_o is low the frequency index, bitrate and both lengths read zero.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder #(
  parameter int unsigned QDepth = mad_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] header_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             header_ok_o,
  output logic [1:0]       layer_number_o,
  output logic             low_rate_ext_o,
  output logic             is_v25_o,
  output logic [3:0]       freq_index_o,
  output logic             crc_present_o,
  output logic [8:0]       bitrate_kbps_o,
  output logic             pad_flag_o,
  output logic [1:0]       chan_mode_o,
  output logic [1:0]       chan_mode_ext_o,
  output logic [8:0]       side_header_bits_o,
  output logic [13:0]      data_bits_o
);

  mad_pkg::class_t front_class;
  mad_pkg::class_t queue_class;
  mad_pkg::class_t res;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  mad_front u_front (
    .word_i  (header_word_i),
    .class_o (front_class)
  );

  mad_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_class),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (queue_class)
  );

  mad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (~q_empty),
    .class_i     (queue_class),
    .take_o      (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .side_bits_o (side_header_bits_o),
    .data_bits_o (data_bits_o)
  );

  assign in_stall_o      = q_full;
  assign header_ok_o     = res.ok;
  assign layer_number_o  = res.layer_number;
  assign low_rate_ext_o  = res.lsf;
  assign is_v25_o        = res.v25;
  assign freq_index_o    = res.freq_index;
  assign crc_present_o   = res.crc;
  assign bitrate_kbps_o  = res.kbps;
  assign pad_flag_o      = res.pad;
  assign chan_mode_o     = res.mode;
  assign chan_mode_ext_o = res.stereo_ext;

endmodule
`default_nettype wire

// ----- verif/mpeg_audio_header_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder_tb
// Self-checking bench for the layer III frame header decoder.
// ----------------------------------------------------------------------------
// Drives candidate header words through the input handshake in random bursts,
// stalls the output on a changing pattern, and checks every decoded word field
// by field against a local decode of the same header. A short directed list
// covers each version, each layer code, the reserved indices, broken sync and
// the length extremes. The random part is mostly sync-correct layer III
// headers with random content, plus corrupted and fully random words.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder_tb;

  localparam logic [1:0] VerMpeg1    = 2'b11;
  localparam logic [1:0] VerMpeg2    = 2'b10;
  localparam logic [1:0] VerMpeg25   = 2'b00;
  localparam logic [1:0] VerReserved = 2'b01;

  localparam logic [1:0] LayerIII  = mad_pkg::LayerBitsL3;
  localparam logic [1:0] LayerII   = 2'b10;
  localparam logic [1:0] LayerI    = 2'b11;
  localparam logic [1:0] LayerRsvd = 2'b00;

  localparam logic [1:0] ModeStereo = 2'b00;
  localparam logic [1:0] ModeJoint  = 2'b01;

  localparam int unsigned NumRandomWords = 1600;
  localparam int unsigned DrainEvery     = 400;

  typedef struct packed {
    logic        ok;
    logic [1:0]  layer;
    logic        lsf;
    logic        v25;
    logic [3:0]  fidx;
    logic        crc;
    logic [8:0]  kbps;
    logic        pad;
    logic [1:0]  mode;
    logic [1:0]  stereo_ext;
    logic [8:0]  hbits;
    logic [13:0] dbits;
  } hdr_fields_t;

  typedef struct {
    logic [31:0] word;
    bit          drain;
  } header_item_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [31:0] header_word_i = '0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        header_ok_o;
  logic [1:0]  layer_number_o;
  logic        low_rate_ext_o;
  logic        is_v25_o;
  logic [3:0]  freq_index_o;
  logic        crc_present_o;
  logic [8:0]  bitrate_kbps_o;
  logic        pad_flag_o;
  logic [1:0]  chan_mode_o;
  logic [1:0]  chan_mode_ext_o;
  logic [8:0]  side_header_bits_o;
  logic [13:0] data_bits_o;

  header_item_t header_words[$];
  hdr_fields_t  pending_results[$];
  hdr_fields_t  want_fields;
  hdr_fields_t  got_fields;
  int unsigned  errors = 0;

  int unsigned  burst_left = 0;
  int unsigned  gap_left   = 0;
  header_item_t next_item;

  logic [1:0]   stall_mode = 2'd0;
  int unsigned  stall_left = 0;

  mpeg_audio_header_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .header_word_i      (header_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .header_ok_o        (header_ok_o),
    .layer_number_o     (layer_number_o),
    .low_rate_ext_o     (low_rate_ext_o),
    .is_v25_o           (is_v25_o),
    .freq_index_o       (freq_index_o),
    .crc_present_o      (crc_present_o),
    .bitrate_kbps_o     (bitrate_kbps_o),
    .pad_flag_o         (pad_flag_o),
    .chan_mode_o        (chan_mode_o),
    .chan_mode_ext_o    (chan_mode_ext_o),
    .side_header_bits_o (side_header_bits_o),
    .data_bits_o        (data_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned sample_hz(input int unsigned idx);
    case (idx)
      0: return 44100;
      1: return 48000;
      2: return 32000;
      3: return 22050;
      4: return 24000;
      5: return 16000;
      6: return 11025;
      7: return 12000;
      default: return 8000;
    endcase
  endfunction

  function automatic int unsigned l3_kbps(input logic lsf, input logic [3:0] idx);
    int unsigned mpeg1_rates[16];
    int unsigned low_rates[16];
    mpeg1_rates = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
    low_rates   = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
    return lsf ? low_rates[idx] : mpeg1_rates[idx];
  endfunction

  function automatic hdr_fields_t decode_header(input logic [31:0] w);
    hdr_fields_t f;
    logic [1:0]  lb;
    logic [1:0]  sf;
    logic [3:0]  br;
    int unsigned idx;
    int unsigned rate;
    int unsigned hbytes;
    int unsigned fbits;
    lb = w[18:17];
    br = w[15:12];
    sf = w[11:10];
    f = '0;
    // four minus the layer bits, wrapped to two bits
    f.layer      = 2'd0 - lb;
    f.v25        = ~w[20];
    f.lsf        = ~w[20] | ~w[19];
    f.crc        = ~w[16];
    f.pad        = w[9];
    f.mode       = w[7:6];
    f.stereo_ext = w[5:4];
    f.ok = (w[31:21] == 11'h7ff) && (lb == LayerIII) && (br != 4'd0) && (br != 4'd15)
           && (sf != 2'd3);
    if (f.ok) begin
      idx = f.v25 ? 6 + sf : sf + (f.lsf ? 3 : 0);
      if (idx > 8) idx = 8;
      f.fidx = idx[3:0];
      rate = l3_kbps(f.lsf, br);
      f.kbps = rate[8:0];
      if (f.lsf) hbytes = (f.mode == mad_pkg::ModeMono) ? 9 : 17;
      else hbytes = (f.mode == mad_pkg::ModeMono) ? 17 : 32;
      if (f.crc) hbytes += 2;
      hbytes += 4;
      f.hbits = 9'(hbytes * 8);
      fbits = ((rate * 144000) / (sample_hz(idx) << f.lsf) + f.pad) * 8;
      if (fbits <= hbytes * 8) f.dbits = '0;
      else if (fbits - hbytes * 8 > 16383) f.dbits = 14'd16383;
      else f.dbits = 14'(fbits - hbytes * 8);
    end
    return f;
  endfunction

  function automatic logic [31:0] make_hdr(input logic [1:0] ver, input logic [1:0] layer,
                                           input logic prot, input logic [3:0] br,
                                           input logic [1:0] sf, input logic pad,
                                           input logic [1:0] mode, input logic [1:0] ext);
    return {11'h7ff, ver, layer, prot, br, sf, pad, 1'b0, mode, ext, 4'h0};
  endfunction

  function automatic logic [31:0] random_header();
    logic [31:0] w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w = $urandom;
    if (pick < 85) begin
      w[31:21] = 11'h7ff;
      w[18:17] = LayerIII;
      if ($urandom_range(0, 9) != 0) begin
        if (w[15:12] == 4'd0 || w[15:12] == 4'd15) w[15:12] = 4'($urandom_range(1, 14));
        if (w[11:10] == 2'd3) w[11:10] = 2'($urandom_range(0, 2));
      end
      // corrupt one bit among bits 10 to 31 of the header
      if (pick >= 70) w[$urandom_range(10, 31)] ^= 1'b1;
    end
    return w;
  endfunction

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Driver: bursts of words with random gaps; hold the word until taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) pending_results.push_back(decode_header(header_word_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (header_words.size() == 0 ||
                     (header_words[0].drain && pending_results.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          next_item = header_words.pop_front();
          in_valid_i <= 1'b1;
          header_word_i <= next_item.word;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Monitor: check each taken word, and stall on a pattern that changes mode.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, header_ok %0b", $time, header_ok_o);
        end else begin
          want_fields = pending_results.pop_front();
          got_fields = '{header_ok_o, layer_number_o, low_rate_ext_o, is_v25_o, freq_index_o,
                         crc_present_o, bitrate_kbps_o, pad_flag_o, chan_mode_o,
                         chan_mode_ext_o, side_header_bits_o, data_bits_o};
          report_field("header_ok", want_fields.ok, got_fields.ok);
          report_field("layer_number", want_fields.layer, got_fields.layer);
          report_field("low_rate_ext", want_fields.lsf, got_fields.lsf);
          report_field("is_v25", want_fields.v25, got_fields.v25);
          report_field("freq_index", want_fields.fidx, got_fields.fidx);
          report_field("crc_present", want_fields.crc, got_fields.crc);
          report_field("bitrate_kbps", want_fields.kbps, got_fields.kbps);
          report_field("pad_flag", want_fields.pad, got_fields.pad);
          report_field("chan_mode", want_fields.mode, got_fields.mode);
          report_field("chan_mode_ext", want_fields.stereo_ext, got_fields.stereo_ext);
          report_field("side_header_bits", want_fields.hbits, got_fields.hbits);
          report_field("data_bits", want_fields.dbits, got_fields.dbits);
        end
      end
      if (stall_left == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        stall_left <= $urandom_range(16, 80);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        2'd0: out_stall_i <= 1'b0;
        2'd1: out_stall_i <= ($urandom_range(0, 7) == 0);
        2'd2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  initial begin
    logic [31:0] directed[$];
    header_item_t item;
    directed = '{
      32'h0000_0000,
      32'hffff_ffff,
      make_hdr(VerMpeg1, LayerIII, 1'b1, 4'd14, 2'd0, 1'b1, ModeStereo, 2'd0),
      make_hdr(VerMpeg1, LayerIII, 1'b0, 4'd1, 2'd2, 1'b0, mad_pkg::ModeMono, 2'd0),
      make_hdr(VerMpeg1, LayerIII, 1'b1, 4'd9, 2'd1, 1'b1, ModeJoint, 2'd3),
      make_hdr(VerMpeg1, LayerIII, 1'b0, 4'd1, 2'd0, 1'b0, mad_pkg::ModeMono, 2'd1),
      make_hdr(VerMpeg2, LayerIII, 1'b0, 4'd1, 2'd1, 1'b0, mad_pkg::ModeMono, 2'd0),
      make_hdr(VerMpeg2, LayerIII, 1'b1, 4'd14, 2'd2, 1'b1, ModeStereo, 2'd0),
      make_hdr(VerMpeg2, LayerIII, 1'b0, 4'd14, 2'd0, 1'b1, ModeJoint, 2'd2),
      make_hdr(VerMpeg25, LayerIII, 1'b0, 4'd1, 2'd2, 1'b0, ModeStereo, 2'd0),
      make_hdr(VerMpeg25, LayerIII, 1'b1, 4'd14, 2'd0, 1'b1, mad_pkg::ModeMono, 2'd0),
      make_hdr(VerMpeg25, LayerIII, 1'b1, 4'd7, 2'd1, 1'b0, mad_pkg::ModeMono, 2'd3),
      make_hdr(VerReserved, LayerIII, 1'b1, 4'd5, 2'd1, 1'b0, ModeJoint, 2'd1),
      make_hdr(VerMpeg1, LayerRsvd, 1'b1, 4'd9, 2'd0, 1'b0, ModeStereo, 2'd0),
      make_hdr(VerMpeg1, LayerII, 1'b1, 4'd9, 2'd0, 1'b0, ModeStereo, 2'd0),
      make_hdr(VerMpeg1, LayerI, 1'b0, 4'd9, 2'd0, 1'b1, mad_pkg::ModeMono, 2'd0),
      make_hdr(VerMpeg1, LayerIII, 1'b1, 4'd0, 2'd0, 1'b0, ModeStereo, 2'd0),
      make_hdr(VerMpeg1, LayerIII, 1'b1, 4'd15, 2'd0, 1'b0, ModeStereo, 2'd0),
      make_hdr(VerMpeg1, LayerIII, 1'b1, 4'd9, 2'd3, 1'b0, ModeStereo, 2'd0),
      make_hdr(VerMpeg1, LayerIII, 1'b1, 4'd9, 2'd0, 1'b0, ModeStereo, 2'd0) & ~32'h0020_0000,
      make_hdr(VerMpeg1, LayerIII, 1'b1, 4'd9, 2'd0, 1'b0, ModeStereo, 2'd0) & ~32'h8000_0000,
      make_hdr(VerMpeg2, LayerIII, 1'b1, 4'd8, 2'd2, 1'b1, ModeJoint, 2'd3) | 32'h0000_010f,
      32'h7fff_ffff
    };
    foreach (directed[i]) begin
      item.word = directed[i];
      item.drain = 1'b0;
      header_words.push_back(item);
    end
    for (int unsigned i = 0; i < NumRandomWords; i++) begin
      item.word = random_header();
      // let the output empty out now and then before sending more
      item.drain = (i % DrainEvery == 0);
      header_words.push_back(item);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (header_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d words pending", $time, pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mad_pkg.sv
rtl/core/mad_front.sv
rtl/core/mad_queue.sv
rtl/core/mad_back.sv
rtl/core/mpeg_audio_header_decoder.sv
verif/mpeg_audio_header_decoder_tb.sv
